[src/group_address_association_lookup_top_defines.svh]
// assertion macros used by the group address lookup datapath
// expects clk and arst_n in the scope where a macro is used
`ifndef GROUP_ADDRESS_ASSOCIATION_LOOKUP_TOP_DEFINES_SVH
`define GROUP_ADDRESS_ASSOCIATION_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define GAAL_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define GAAL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/gaal_pkg.sv]
// shared types and constants for the group address association lookup
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gaal_pkg;

	localparam int GAAL_TABLE_ENTRIES = 32;
	localparam int IDX_W      = 6;
	localparam int GA_W       = 16;
	localparam int ASSOC_W    = 2 * IDX_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam int FUNC_W     = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_WR_ADDR     = 3'd0,
		FN_WR_ASSOC    = 3'd1,
		FN_OBJ_BY_ADDR = 3'd2,
		FN_ADDR_BY_OBJ = 3'd3,
		FN_KNOWN       = 3'd4,
		FN_NEXT_ASSOC  = 3'd5
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADDR_COUNT  = 1'b0,
		CFG_ASSOC_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SC_ADDR_GA,
		SC_ASSOC_ADDR,
		SC_ASSOC_OBJ
	} scan_mode_t;

	typedef enum logic [1:0] {
		RD_SCAN,
		RD_ENTRY,
		RD_HADDR
	} rd_sel_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  entry_index;
		logic [IDX_W-1:0]  addr_index;
		logic [GA_W-1:0]   group_addr;
		logic [IDX_W-1:0]  object_index;
	} req_t;

	typedef struct packed {
		logic             status;
		logic [IDX_W-1:0] found_object;
		logic [GA_W-1:0]  found_addr;
		logic [IDX_W-1:0] next_entry;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       write;
		logic       scan_start;
		scan_mode_t scan_mode;
		logic       scan_from_entry;
		logic       scan_run;
		logic       key_from_hit;
		logic       key_load;
		rd_sel_t    rd_sel;
		logic       faddr_load;
		logic       finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              entry_ok;
		logic              haddr_ok;
		logic              hit;
		logic              scan_end;
		logic              out_free;
	} sts_t;

endpackage

`default_nettype wire

[src/gaal_if.sv]
// request and response channel interfaces, valid/ready with a packed payload
// depends on gaal_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gaal_req_if import gaal_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gaal_rsp_if import gaal_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/gaal_ctrl.sv]
// sequencer for the lookup: issues table writes and walks each lookup through its table scans
// depends on gaal_pkg
`timescale 1ns / 1ps
`default_nettype none

module gaal_ctrl import gaal_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN_A,
		ST_SCAN_B,
		ST_RD_KEY,
		ST_WAIT_KEY,
		ST_RD_ADDR,
		ST_WAIT_ADDR,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_nx;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		cmd.scan_mode = SC_ADDR_GA;
		cmd.rd_sel    = RD_SCAN;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.func)
					FN_WR_ADDR, FN_WR_ASSOC: begin
						cmd.write = 1'b1;
						state_nx  = ST_FINISH;
					end
					FN_OBJ_BY_ADDR, FN_KNOWN: begin
						cmd.scan_start = 1'b1;
						cmd.scan_mode  = SC_ADDR_GA;
						state_nx       = ST_SCAN_A;
					end
					FN_ADDR_BY_OBJ: begin
						cmd.scan_start = 1'b1;
						cmd.scan_mode  = SC_ASSOC_OBJ;
						state_nx       = ST_SCAN_B;
					end
					FN_NEXT_ASSOC: begin
						state_nx = sts.entry_ok ? ST_RD_KEY : ST_FINISH;
					end
					default: state_nx = ST_FINISH;
				endcase
			end
			ST_SCAN_A: begin
				cmd.scan_run = 1'b1;
				if (sts.hit) begin
					if (sts.func == FN_OBJ_BY_ADDR) begin
						// address index found, now look for its first association
						cmd.scan_start   = 1'b1;
						cmd.scan_mode    = SC_ASSOC_ADDR;
						cmd.key_from_hit = 1'b1;
						state_nx         = ST_SCAN_B;
					end else begin
						state_nx = ST_FINISH;
					end
				end else if (sts.scan_end) begin
					state_nx = ST_FINISH;
				end
			end
			ST_SCAN_B: begin
				cmd.scan_run = 1'b1;
				if (sts.hit) begin
					state_nx = (sts.func == FN_ADDR_BY_OBJ) ? ST_RD_ADDR : ST_FINISH;
				end else if (sts.scan_end) begin
					state_nx = ST_FINISH;
				end
			end
			ST_RD_KEY: begin
				cmd.rd_sel = RD_ENTRY;
				state_nx   = ST_WAIT_KEY;
			end
			ST_WAIT_KEY: begin
				cmd.key_load        = 1'b1;
				cmd.scan_start      = 1'b1;
				cmd.scan_mode       = SC_ASSOC_ADDR;
				cmd.scan_from_entry = 1'b1;
				state_nx            = ST_SCAN_B;
			end
			ST_RD_ADDR: begin
				if (sts.haddr_ok) begin
					cmd.rd_sel = RD_HADDR;
					state_nx   = ST_WAIT_ADDR;
				end else begin
					state_nx = ST_FINISH;
				end
			end
			ST_WAIT_ADDR: begin
				cmd.faddr_load = 1'b1;
				state_nx       = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

`default_nettype wire

[src/gaal_dpath.sv]
// tables, scan pipeline, count registers and result register of the lookup
// depends on gaal_pkg, gaal_if and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none

`include "group_address_association_lookup_top_defines.svh"

module gaal_dpath import gaal_pkg::*; #(
	parameter int TABLE_ENTRIES = GAAL_TABLE_ENTRIES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  req_t                  req_data,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	gaal_rsp_if.source            rsp
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = (AW > IDX_W) ? AW : IDX_W;

	logic [GA_W-1:0]    addr_mem  [TABLE_ENTRIES];
	logic [ASSOC_W-1:0] assoc_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] addr_vld_q;
	logic [TABLE_ENTRIES-1:0] assoc_vld_q;

	req_t             item_q;
	logic [IDX_W-1:0] addr_cnt_q;
	logic [IDX_W-1:0] assoc_cnt_q;
	logic [IDX_W-1:0] n_addr;
	logic [IDX_W-1:0] n_assoc;

	scan_mode_t       mode_q;
	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] key_q;
	logic [IDX_W-1:0] lim;
	logic             scan_more;
	logic             issue;

	logic             pend_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [GA_W-1:0]    addr_rd_s1;
	logic [ASSOC_W-1:0] assoc_rd_s1;
	logic             rd_vld_a_s1;
	logic             rd_vld_b_s1;
	logic [GA_W-1:0]  addr_data;
	logic [IDX_W-1:0] assoc_a;
	logic [IDX_W-1:0] assoc_o;
	logic             match_s1;

	logic             found_q;
	logic [IDX_W-1:0] hit_pos_q;
	logic [IDX_W-1:0] hit_addr_q;
	logic [IDX_W-1:0] hit_obj_q;
	logic [GA_W-1:0]  faddr_q;

	logic             wr_addr_ok;
	logic             wr_assoc_ok;
	logic             we_a;
	logic             we_b;
	logic [IDX_W-1:0] rd_idx;
	logic [CW-1:0]    rd_ext;
	logic [CW-1:0]    wa_ext;
	logic [CW-1:0]    wb_ext;
	logic [AW-1:0]    ra;
	logic [AW-1:0]    wa;
	logic [AW-1:0]    wb;
	logic             out_free;
	rsp_t             res;
	rsp_t             out_q;
	logic             out_valid_q;

	// a count above the table size means the whole table
	assign n_addr  = (32'(addr_cnt_q) > 32'(TABLE_ENTRIES)) ? IDX_W'(TABLE_ENTRIES) : addr_cnt_q;
	assign n_assoc = (32'(assoc_cnt_q) > 32'(TABLE_ENTRIES)) ? IDX_W'(TABLE_ENTRIES) : assoc_cnt_q;

	assign wr_addr_ok = (item_q.addr_index != '0)
		&& (32'(item_q.addr_index) <= 32'(TABLE_ENTRIES))
		&& (item_q.group_addr != '0);
	assign wr_assoc_ok = (item_q.entry_index != '0)
		&& (32'(item_q.entry_index) <= 32'(TABLE_ENTRIES))
		&& (item_q.addr_index != '0) && (item_q.object_index != '0);

	assign we_a = cmd.write && (item_q.func == FN_WR_ADDR) && wr_addr_ok;
	assign we_b = cmd.write && (item_q.func == FN_WR_ASSOC) && wr_assoc_ok;

	// one-based indices to table addresses
	assign wa_ext = CW'(item_q.addr_index - IDX_W'(1));
	assign wb_ext = CW'(item_q.entry_index - IDX_W'(1));
	assign wa     = wa_ext[AW-1:0];
	assign wb     = wb_ext[AW-1:0];

	always_comb begin
		case (cmd.rd_sel)
			RD_ENTRY: rd_idx = item_q.entry_index - IDX_W'(1);
			RD_HADDR: rd_idx = hit_addr_q - IDX_W'(1);
			default:  rd_idx = scan_q;
		endcase
	end
	assign rd_ext = CW'(rd_idx);
	assign ra     = rd_ext[AW-1:0];

	// entries never written read as zero
	assign addr_data = rd_vld_a_s1 ? addr_rd_s1 : '0;
	assign assoc_a   = rd_vld_b_s1 ? assoc_rd_s1[ASSOC_W-1:IDX_W] : '0;
	assign assoc_o   = rd_vld_b_s1 ? assoc_rd_s1[IDX_W-1:0] : '0;

	assign lim       = (mode_q == SC_ADDR_GA) ? n_addr : n_assoc;
	assign scan_more = (scan_q < lim);

	always_comb begin
		case (mode_q)
			SC_ADDR_GA:    match_s1 = pend_s1 && (addr_data == item_q.group_addr);
			SC_ASSOC_ADDR: match_s1 = pend_s1 && (assoc_a == key_q);
			SC_ASSOC_OBJ:  match_s1 = pend_s1 && (assoc_o == item_q.object_index);
			default:       match_s1 = 1'b0;
		endcase
	end

	assign issue = cmd.scan_run && !match_s1 && scan_more;

	// table storage with registered read
	always_ff @(posedge clk) begin
		if (we_a) begin
			addr_mem[wa] <= item_q.group_addr;
		end
		if (we_b) begin
			assoc_mem[wb] <= {item_q.addr_index, item_q.object_index};
		end
		addr_rd_s1  <= addr_mem[ra];
		assoc_rd_s1 <= assoc_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_vld_q  <= '0;
			assoc_vld_q <= '0;
			addr_cnt_q  <= '0;
			assoc_cnt_q <= '0;
			rd_vld_a_s1 <= 1'b0;
			rd_vld_b_s1 <= 1'b0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			mode_q      <= SC_ADDR_GA;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ADDR_COUNT:  addr_cnt_q  <= cfg_wdata;
					CFG_ASSOC_COUNT: assoc_cnt_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (we_a) begin
				addr_vld_q[wa] <= 1'b1;
			end
			if (we_b) begin
				assoc_vld_q[wb] <= 1'b1;
			end
			rd_vld_a_s1 <= addr_vld_q[ra];
			rd_vld_b_s1 <= assoc_vld_q[ra];

			if (cmd.scan_start) begin
				mode_q  <= cmd.scan_mode;
				pend_s1 <= 1'b0;
				found_q <= 1'b0;
			end else begin
				pend_s1 <= issue;
				if (cmd.load) begin
					found_q <= 1'b0;
				end else if (cmd.scan_run && match_s1) begin
					found_q <= 1'b1;
				end
			end

			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= req_data;
			faddr_q <= '0;
		end else if (cmd.faddr_load) begin
			faddr_q <= addr_data;
		end
		if (cmd.scan_start) begin
			scan_q <= cmd.scan_from_entry ? item_q.entry_index : '0;
		end else if (issue) begin
			scan_q <= scan_q + IDX_W'(1);
		end
		if (issue) begin
			idx_s1 <= scan_q;
		end
		if (cmd.key_from_hit) begin
			key_q <= idx_s1 + IDX_W'(1);
		end else if (cmd.key_load) begin
			key_q <= assoc_a;
		end
		if (cmd.scan_run && match_s1) begin
			hit_pos_q  <= idx_s1 + IDX_W'(1);
			hit_addr_q <= assoc_a;
			hit_obj_q  <= assoc_o;
		end
		if (cmd.finish) begin
			out_q <= res;
		end
	end

	always_comb begin
		res = '0;
		case (item_q.func)
			FN_WR_ADDR:  res.status = !wr_addr_ok;
			FN_WR_ASSOC: res.status = !wr_assoc_ok;
			FN_OBJ_BY_ADDR: begin
				res.status       = !found_q;
				res.found_object = found_q ? hit_obj_q : '0;
			end
			FN_ADDR_BY_OBJ: begin
				res.status     = (faddr_q == '0);
				res.found_addr = faddr_q;
			end
			FN_KNOWN: res.status = !found_q;
			FN_NEXT_ASSOC: begin
				res.status     = !found_q;
				res.next_entry = found_q ? hit_pos_q : '0;
			end
			default: res.status = 1'b1;
		endcase
	end

	assign out_free = !out_valid_q || rsp.ready;

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign sts.func     = item_q.func;
	assign sts.entry_ok = (item_q.entry_index != '0) && (item_q.entry_index <= n_assoc);
	assign sts.haddr_ok = (hit_addr_q != '0) && (hit_addr_q <= n_addr);
	assign sts.hit      = match_s1;
	assign sts.scan_end = !pend_s1 && !scan_more;
	assign sts.out_free = out_free;

	`GAAL_ASSERT_IMPL(a_scan_in_range, pend_s1, idx_s1 < lim, "scan read past entries in use")
	`GAAL_ASSERT_IMPL(a_match_after_issue, match_s1, $past(cmd.scan_run), "match without scan")
	`GAAL_ASSERT_IMPL(a_haddr_read_ok, cmd.rd_sel == RD_HADDR, sts.haddr_ok, "bad address read")
	`GAAL_ASSERT_IMPL(a_finish_free, cmd.finish, out_free, "result register overwritten")
	`GAAL_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid_q, "finished item not presented")

endmodule

`default_nettype wire

[src/group_address_association_lookup_top.sv]
// top level of the group address association lookup: controller plus datapath
// depends on gaal_pkg, gaal_if, gaal_ctrl and gaal_dpath
//
//   channel  dir  payload                                          handshake
//   req      in   func, entry_index, addr_index, group_addr,       valid/ready
//                 object_index
//   rsp      out  status, found_object, found_addr, next_entry     valid/ready
//   cfg      in   cfg_index, cfg_wdata (addr_count, assoc_count)   cfg_we
//
// writes and rejected or unused operations go from dispatch straight to the finish state;
// a new item is taken only once the controller is back in idle
// lookups run their table scans to a hit or to the end of the entries in use; each table has one
// read port and the scans visit one entry a cycle through a registered read
// the next item is accepted while a result still waits in the output register
// tables clear at reset through per-entry valid bits, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module group_address_association_lookup_top import gaal_pkg::*; #(
	parameter int TABLE_ENTRIES = GAAL_TABLE_ENTRIES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	gaal_req_if.sink              req,
	gaal_rsp_if.source            rsp
);

	cmd_t cmd;
	sts_t sts;

	gaal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gaal_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_data  (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

[sim/tb.sv]
// testbench for the group address association lookup: directed table, then random phases
// depends on gaal_pkg, gaal_if and group_address_association_lookup_top
`timescale 1ns / 1ps

module tb import gaal_pkg::*; ();

	localparam int STUCK_LIMIT = 5000;
	localparam int HOLD_LEN    = 400;
	localparam int SETTLE      = 80;
	localparam int PHASE_ITEMS = 130;
	localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

	typedef struct {
		bit              set_counts;
		logic [IDX_W-1:0] addr_cnt;
		logic [IDX_W-1:0] assoc_cnt;
		req_t            item;
		bit              typed;
		rsp_t            answer;
	} step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	gaal_req_if req_ch ();
	gaal_rsp_if rsp_ch ();

	group_address_association_lookup_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// shadow tables and counts
	logic [GA_W-1:0]  ga_tab    [GAAL_TABLE_ENTRIES];
	logic [IDX_W-1:0] link_addr [GAAL_TABLE_ENTRIES];
	logic [IDX_W-1:0] link_obj  [GAAL_TABLE_ENTRIES];
	logic [IDX_W-1:0] addr_cnt;
	logic [IDX_W-1:0] assoc_cnt;

	rsp_t        answer_q [$];
	step_t       directed_q [$];
	logic [15:0] ga_pool [8];
	int          errors;
	int          stuck_cycles;
	int          send_idle_pct;
	int          stall_pct;
	bit          hold_req;
	bit          hold_ack;
	int          hold_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned in_use(logic [IDX_W-1:0] cnt);
		return (cnt > GAAL_TABLE_ENTRIES) ? GAAL_TABLE_ENTRIES : 32'(cnt);
	endfunction

	// works out the answer to one item and applies any table write
	function automatic rsp_t lookup_model(req_t r);
		rsp_t        a;
		int unsigned na;
		int unsigned nl;
		int unsigned hit;
		int unsigned key;
		bit          found;
		a = '0;
		a.status = 1'b1;
		na = in_use(addr_cnt);
		nl = in_use(assoc_cnt);
		hit = 0;
		found = 1'b0;
		case (r.func)
			FN_WR_ADDR: begin
				if (r.addr_index != 0 && r.addr_index <= GAAL_TABLE_ENTRIES &&
						r.group_addr != 0) begin
					ga_tab[r.addr_index - 1] = r.group_addr;
					a.status = 1'b0;
				end
			end
			FN_WR_ASSOC: begin
				if (r.entry_index != 0 && r.entry_index <= GAAL_TABLE_ENTRIES &&
						r.addr_index != 0 && r.object_index != 0) begin
					link_addr[r.entry_index - 1] = r.addr_index;
					link_obj[r.entry_index - 1] = r.object_index;
					a.status = 1'b0;
				end
			end
			FN_OBJ_BY_ADDR: begin
				for (int i = 0; i < na; i++)
					if (hit == 0 && ga_tab[i] == r.group_addr)
						hit = i + 1;
				if (hit != 0)
					for (int i = 0; i < nl; i++)
						if (a.status && link_addr[i] == hit) begin
							a.found_object = link_obj[i];
							a.status = 1'b0;
						end
			end
			FN_ADDR_BY_OBJ: begin
				for (int i = 0; i < nl; i++)
					if (!found && link_obj[i] == r.object_index) begin
						found = 1'b1;
						hit = 32'(link_addr[i]);
					end
				if (hit != 0 && hit <= na)
					a.found_addr = ga_tab[hit - 1];
				a.status = (a.found_addr == 0);
			end
			FN_KNOWN: begin
				for (int i = 0; i < na; i++)
					if (ga_tab[i] == r.group_addr)
						a.status = 1'b0;
			end
			FN_NEXT_ASSOC: begin
				if (r.entry_index != 0 && r.entry_index <= nl) begin
					key = 32'(link_addr[r.entry_index - 1]);
					for (int i = 32'(r.entry_index); i < nl; i++)
						if (a.status && link_addr[i] == key) begin
							a.next_entry = 6'(i + 1);
							a.status = 1'b0;
						end
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic step_t row(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] e,
			logic [IDX_W-1:0] ai, logic [GA_W-1:0] g, logic [IDX_W-1:0] o);
		step_t s;
		s = '{default: '0};
		s.item.func = f;
		s.item.entry_index = e;
		s.item.addr_index = ai;
		s.item.group_addr = g;
		s.item.object_index = o;
		return s;
	endfunction

	function automatic step_t answer(step_t s, logic st, logic [IDX_W-1:0] fo,
			logic [GA_W-1:0] fa, logic [IDX_W-1:0] ne);
		s.typed = 1'b1;
		s.answer.status = st;
		s.answer.found_object = fo;
		s.answer.found_addr = fa;
		s.answer.next_entry = ne;
		return s;
	endfunction

	function automatic step_t counts_row(logic [IDX_W-1:0] na, logic [IDX_W-1:0] nl);
		step_t s;
		s = '{default: '0};
		s.set_counts = 1'b1;
		s.addr_cnt = na;
		s.assoc_cnt = nl;
		return s;
	endfunction

	function automatic logic [IDX_W-1:0] pick_count();
		int unsigned k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return '0;
		if (k == 1)
			return 6'(GAAL_TABLE_ENTRIES);
		if (k == 2)
			return 6'($urandom_range(GAAL_TABLE_ENTRIES + 1, 63));
		return 6'($urandom_range(1, GAAL_TABLE_ENTRIES));
	endfunction

	// mostly well-formed items drawn from small index and address sets so lookups hit
	function automatic req_t rand_item();
		req_t        r;
		int unsigned k;
		r.func = 3'($urandom_range(0, 7));
		r.entry_index = 6'($urandom_range(0, 63));
		r.addr_index = 6'($urandom_range(0, 63));
		r.group_addr = 16'($urandom_range(0, 65535));
		r.object_index = 6'($urandom_range(0, 63));
		if ($urandom_range(0, 99) < 8)
			return r;
		k = $urandom_range(0, 99);
		if (k < 20)
			r.func = FN_WR_ADDR;
		else if (k < 40)
			r.func = FN_WR_ASSOC;
		else if (k < 55)
			r.func = FN_OBJ_BY_ADDR;
		else if (k < 70)
			r.func = FN_ADDR_BY_OBJ;
		else if (k < 82)
			r.func = FN_KNOWN;
		else if (k < 97)
			r.func = FN_NEXT_ASSOC;
		if ($urandom_range(0, 9) != 0)
			r.entry_index = 6'($urandom_range(1, GAAL_TABLE_ENTRIES));
		if ($urandom_range(0, 3) != 0)
			r.addr_index = 6'($urandom_range(1, 10));
		else if ($urandom_range(0, 3) != 0)
			r.addr_index = 6'($urandom_range(1, GAAL_TABLE_ENTRIES));
		if ($urandom_range(0, 99) < 85)
			r.group_addr = ga_pool[$urandom_range(0, 7)];
		if ($urandom_range(0, 99) < 85)
			r.object_index = 6'($urandom_range(1, 12));
		return r;
	endfunction

	task automatic send_item(req_t r, bit typed, rsp_t typed_answer);
		rsp_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		predicted = lookup_model(r);
		answer_q.push_back(typed ? typed_answer : predicted);
	endtask

	// drops valid and waits for every outstanding answer
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_counts(logic [IDX_W-1:0] na, logic [IDX_W-1:0] nl);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ADDR_COUNT;
		cfg_wdata <= na;
		@(posedge clk);
		cfg_index <= CFG_ASSOC_COUNT;
		cfg_wdata <= nl;
		@(posedge clk);
		cfg_we <= 1'b0;
		addr_cnt = na;
		assoc_cnt = nl;
	endtask

	task automatic check_field(string name, logic [GA_W-1:0] want, logic [GA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// receiver: random stalls, or a long hold when asked
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cnt <= HOLD_LEN;
			rsp_ch.ready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : answer_check
		rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (answer_q.size() == 0) begin
				$error("result item with no expectation outstanding");
				errors++;
			end else begin
				want = answer_q.pop_front();
				check_field("status", 16'(want.status), 16'(rsp_ch.data.status));
				check_field("found_object", 16'(want.found_object),
					16'(rsp_ch.data.found_object));
				check_field("found_addr", want.found_addr, rsp_ch.data.found_addr);
				check_field("next_entry", 16'(want.next_entry), 16'(rsp_ch.data.next_entry));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles == STUCK_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int    idle_by_phase [5];
		int    stall_by_phase [5];
		step_t s;
		idle_by_phase = '{0, 66, 0, 38, 0};
		stall_by_phase = '{0, 0, 66, 38, 0};
		errors = 0;
		stuck_cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		hold_ack = 1'b0;
		hold_cnt = 0;
		addr_cnt = '0;
		assoc_cnt = '0;
		foreach (ga_tab[i]) begin
			ga_tab[i] = '0;
			link_addr[i] = '0;
			link_obj[i] = '0;
		end
		foreach (ga_pool[i])
			ga_pool[i] = 16'($urandom_range(1, 65535));
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ADDR_COUNT;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;

		// counts are zero after reset, so nothing is in use
		directed_q.push_back(answer(row(FN_KNOWN, 0, 0, 0, 0), 1'b1, '0, '0, '0));
		directed_q.push_back(answer(row(FN_OBJ_BY_ADDR, 0, 0, 0, 0), 1'b1, '0, '0, '0));
		directed_q.push_back(answer(row(FN_NEXT_ASSOC, 1, 0, 0, 0), 1'b1, '0, '0, '0));
		// address write rejects and accepts
		directed_q.push_back(answer(row(FN_WR_ADDR, 0, 0, 16'h1234, 0), 1'b1, '0, '0, '0));
		directed_q.push_back(answer(row(FN_WR_ADDR, 0, 33, 16'h1234, 0), 1'b1, '0, '0, '0));
		directed_q.push_back(answer(row(FN_WR_ADDR, 0, 1, 16'h0000, 0), 1'b1, '0, '0, '0));
		directed_q.push_back(answer(row(FN_WR_ADDR, 63, 63, 16'hffff, 63), 1'b1, '0, '0, '0));
		directed_q.push_back(answer(row(FN_WR_ADDR, 0, 1, 16'hffff, 0), 1'b0, '0, '0, '0));
		directed_q.push_back(answer(row(FN_WR_ADDR, 0, 32, 16'h0001, 0), 1'b0, '0, '0, '0));
		// association write rejects and accepts, then unused functions
		directed_q.push_back(answer(row(FN_WR_ASSOC, 0, 1, 0, 5), 1'b1, '0, '0, '0));
		directed_q.push_back(answer(row(FN_WR_ASSOC, 33, 1, 0, 5), 1'b1, '0, '0, '0));
		directed_q.push_back(answer(row(FN_WR_ASSOC, 1, 0, 0, 5), 1'b1, '0, '0, '0));
		directed_q.push_back(answer(row(FN_WR_ASSOC, 1, 1, 0, 0), 1'b1, '0, '0, '0));
		directed_q.push_back(answer(row(FN_WR_ASSOC, 1, 1, 0, 63), 1'b0, '0, '0, '0));
		directed_q.push_back(answer(row(FN_WR_ASSOC, 32, 63, 0, 1), 1'b0, '0, '0, '0));
		directed_q.push_back(answer(row(FN_WR_ASSOC, 2, 1, 0, 5), 1'b0, '0, '0, '0));
		directed_q.push_back(answer(row(FN_UNUSED_6, 63, 63, 16'hffff, 63), 1'b1, '0, '0, '0));
		directed_q.push_back(answer(row(FN_UNUSED_7, 63, 63, 16'hffff, 63), 1'b1, '0, '0, '0));
		// counts above the table size are clipped
		directed_q.push_back(counts_row(63, 63));
		directed_q.push_back(row(FN_OBJ_BY_ADDR, 0, 0, 16'hffff, 0));
		directed_q.push_back(row(FN_ADDR_BY_OBJ, 0, 0, 0, 63));
		// association points past the in-use address count
		directed_q.push_back(row(FN_ADDR_BY_OBJ, 0, 0, 0, 1));
		directed_q.push_back(row(FN_ADDR_BY_OBJ, 0, 0, 0, 0));
		// zero address matches a never-written entry
		directed_q.push_back(row(FN_KNOWN, 0, 0, 16'h0000, 0));
		directed_q.push_back(row(FN_NEXT_ASSOC, 1, 0, 0, 0));
		directed_q.push_back(row(FN_NEXT_ASSOC, 33, 0, 0, 0));
		directed_q.push_back(counts_row(1, 2));
		directed_q.push_back(row(FN_OBJ_BY_ADDR, 0, 0, 16'h0001, 0));
		directed_q.push_back(row(FN_NEXT_ASSOC, 2, 0, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i]) begin
			s = directed_q[i];
			if (s.set_counts) begin
				drain();
				set_counts(s.addr_cnt, s.assoc_cnt);
			end else begin
				send_item(s.item, s.typed, s.answer);
			end
		end

		for (int p = 0; p < 5; p++) begin
			drain();
			send_idle_pct = idle_by_phase[p];
			stall_pct <= stall_by_phase[p];
			if (p == 0)
				set_counts(6'(GAAL_TABLE_ENTRIES), 6'(GAAL_TABLE_ENTRIES));
			else
				set_counts(pick_count(), pick_count());
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 45 == 44) begin
					drain();
					set_counts(pick_count(), pick_count());
				end
				// last phase: long receiver hold while items keep coming
				if (p == 4 && n == 10)
					hold_req <= ~hold_req;
				send_item(rand_item(), 1'b0, '0);
			end
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
